[design/rfa_pkg.sv]
// Shared widths, data types and helpers for the acoustic Rusanov flux block.
package rfa_pkg;

   // Number format and data widths
   localparam int FRAC_BITS = 16;
   localparam int SHIFT     = FRAC_BITS + 1;
   localparam int WORD_W    = 32;
   localparam int SUM_W     = WORD_W + 1;
   localparam int RAD_W     = 2 * WORD_W;
   localparam int ROOT_W    = WORD_W;
   localparam int REM_W     = ROOT_W + 3;
   localparam int ROOT_CELLS = ROOT_W;
   localparam int PROD_W    = 2 * SUM_W;
   localparam int ACC_W     = PROD_W + 2;

   localparam logic [WORD_W-1:0] SAT_MAX = {1'b0, {(WORD_W-1){1'b1}}};
   localparam logic [WORD_W-1:0] SAT_MIN = {1'b1, {(WORD_W-1){1'b0}}};

   // Face operands after the first stage: normal plus the sums and differences
   typedef struct packed {
      logic signed [WORD_W-1:0] nx;
      logic signed [WORD_W-1:0] ny;
      logic signed [SUM_W-1:0]  sp;
      logic signed [SUM_W-1:0]  su;
      logic signed [SUM_W-1:0]  sv;
      logic signed [SUM_W-1:0]  dp;
      logic signed [SUM_W-1:0]  du;
      logic signed [SUM_W-1:0]  dv;
   } face_type;

   // One item as it moves through the square root cells
   typedef struct packed {
      face_type          face;
      logic [RAD_W-1:0]  rad;
      logic [REM_W-1:0]  rem;
      logic [ROOT_W-1:0] root;
   } root_type;

   // Floor divide by 2^SHIFT and saturate to a signed word
   function automatic logic [WORD_W-1:0] sat_word(input logic signed [ACC_W-1:0] n);
      logic signed [ACC_W-1:0] q;
      logic [WORD_W-1:0]       r;
      q = n >>> SHIFT;
      if ((&q[ACC_W-1:WORD_W-1]) || !(|q[ACC_W-1:WORD_W-1])) begin
         r = q[WORD_W-1:0];
      end else if (q[ACC_W-1]) begin
         r = SAT_MIN;
      end else begin
         r = SAT_MAX;
      end
      return r;
   endfunction

endpackage

[design/rfa_norm.sv]
// Input stages: operand sums and differences, squared normal, and the radicand.
module rfa_norm
   import rfa_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     up_valid,
   output logic                     up_ready,
   input  logic signed [WORD_W-1:0] left_p,
   input  logic signed [WORD_W-1:0] left_u,
   input  logic signed [WORD_W-1:0] left_v,
   input  logic signed [WORD_W-1:0] right_p,
   input  logic signed [WORD_W-1:0] right_u,
   input  logic signed [WORD_W-1:0] right_v,
   input  logic signed [WORD_W-1:0] normal_x,
   input  logic signed [WORD_W-1:0] normal_y,
   output logic                     dn_valid,
   input  logic                     dn_ready,
   output root_type                 dn_node
);

   logic             sq_valid_ff;
   logic             sq_ready;
   face_type         face_ff, face_in;
   logic [RAD_W-1:0] sq_x_ff, sq_x_in;
   logic [RAD_W-1:0] sq_y_ff, sq_y_in;
   logic [WORD_W-1:0] mag_x, mag_y;
   logic             node_valid_ff;
   root_type         node_ff, node_in;

   // Form sums, differences and squared normal components
   always_comb begin
      face_in.nx = normal_x;
      face_in.ny = normal_y;
      face_in.sp = SUM_W'(left_p) + SUM_W'(right_p);
      face_in.su = SUM_W'(left_u) + SUM_W'(right_u);
      face_in.sv = SUM_W'(left_v) + SUM_W'(right_v);
      face_in.dp = SUM_W'(right_p) - SUM_W'(left_p);
      face_in.du = SUM_W'(right_u) - SUM_W'(left_u);
      face_in.dv = SUM_W'(right_v) - SUM_W'(left_v);
      mag_x = normal_x[WORD_W-1] ? (~normal_x + WORD_W'(1)) : normal_x;
      mag_y = normal_y[WORD_W-1] ? (~normal_y + WORD_W'(1)) : normal_y;
      sq_x_in = RAD_W'(mag_x) * RAD_W'(mag_x);
      sq_y_in = RAD_W'(mag_y) * RAD_W'(mag_y);
   end

   assign sq_ready = !node_valid_ff || dn_ready;
   assign up_ready = !sq_valid_ff || sq_ready;

   // Hold the squares until the radicand stage takes them
   always_ff @(posedge clock) begin
      if (reset) begin
         sq_valid_ff <= 1'b0;
      end else if (up_ready) begin
         sq_valid_ff <= up_valid;
      end
      if (up_valid && up_ready) begin
         face_ff <= face_in;
         sq_x_ff <= sq_x_in;
         sq_y_ff <= sq_y_in;
      end
   end

   // Start the root with an empty remainder and root
   always_comb begin
      node_in.face = face_ff;
      node_in.rad  = sq_x_ff + sq_y_ff;
      node_in.rem  = '0;
      node_in.root = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         node_valid_ff <= 1'b0;
      end else if (sq_ready) begin
         node_valid_ff <= sq_valid_ff;
      end
      if (sq_valid_ff && sq_ready) begin
         node_ff <= node_in;
      end
   end

   assign dn_valid = node_valid_ff;
   assign dn_node  = node_ff;

endmodule

[design/rfa_root_cell.sv]
// One cell of the square root chain: settles one root bit per item.
module rfa_root_cell
   import rfa_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     up_valid,
   output logic     up_ready,
   input  root_type up_node,
   output logic     dn_valid,
   input  logic     dn_ready,
   output root_type dn_node
);

   logic             valid_ff;
   root_type         node_ff, node_in;
   logic [REM_W-1:0] rem_shift;
   logic [REM_W-1:0] trial;
   logic             take;

   // Bring in two radicand bits and try the next root bit
   always_comb begin
      rem_shift = {up_node.rem[REM_W-3:0], up_node.rad[RAD_W-1 -: 2]};
      trial     = {1'b0, up_node.root, 2'b01};
      take      = rem_shift >= trial;
      node_in.face = up_node.face;
      node_in.rad  = {up_node.rad[RAD_W-3:0], 2'b00};
      node_in.rem  = take ? (rem_shift - trial) : rem_shift;
      node_in.root = {up_node.root[ROOT_W-2:0], take};
   end

   assign up_ready = !valid_ff || dn_ready;

   // Advance when the neighbor downstream has room
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
      if (up_valid && up_ready) begin
         node_ff <= node_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_node  = node_ff;

   // The remainder never exceeds twice the partial root
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (node_ff.rem <= REM_W'({node_ff.root, 1'b0})))
      else $error("root cell remainder out of range");

endmodule

[design/rfa_flux_tail.sv]
// Output stages: the seven products, the negated numerators, then floor and saturate.
module rfa_flux_tail
   import rfa_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              up_valid,
   output logic              up_ready,
   input  face_type          up_face,
   input  logic [ROOT_W-1:0] up_root,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [WORD_W-1:0] rsp_flux_p,
   output logic [WORD_W-1:0] rsp_flux_u,
   output logic [WORD_W-1:0] rsp_flux_v
);

   logic                    mul_valid_ff, mul_ready;
   logic signed [SUM_W-1:0] s_op, nx_op, ny_op;
   logic signed [PROD_W-1:0] nx_su_ff, ny_sv_ff, s_dp_ff, nx_sp_ff, s_du_ff, ny_sp_ff, s_dv_ff;
   logic signed [PROD_W-1:0] nx_su_in, ny_sv_in, s_dp_in, nx_sp_in, s_du_in, ny_sp_in, s_dv_in;
   logic                    acc_valid_ff, acc_ready;
   logic signed [ACC_W-1:0] acc_p_ff, acc_u_ff, acc_v_ff;
   logic signed [ACC_W-1:0] acc_p_in, acc_u_in, acc_v_in;
   logic                    out_valid_ff;
   logic [WORD_W-1:0]       flux_p_ff, flux_u_ff, flux_v_ff;

   // Multiply: root and normal against sums and differences
   always_comb begin
      s_op  = {1'b0, up_root};
      nx_op = SUM_W'(up_face.nx);
      ny_op = SUM_W'(up_face.ny);
      nx_su_in = PROD_W'(nx_op) * PROD_W'(up_face.su);
      ny_sv_in = PROD_W'(ny_op) * PROD_W'(up_face.sv);
      s_dp_in  = PROD_W'(s_op) * PROD_W'(up_face.dp);
      nx_sp_in = PROD_W'(nx_op) * PROD_W'(up_face.sp);
      s_du_in  = PROD_W'(s_op) * PROD_W'(up_face.du);
      ny_sp_in = PROD_W'(ny_op) * PROD_W'(up_face.sp);
      s_dv_in  = PROD_W'(s_op) * PROD_W'(up_face.dv);
   end

   assign acc_ready = !out_valid_ff || rsp_ready;
   assign mul_ready = !acc_valid_ff || acc_ready;
   assign up_ready  = !mul_valid_ff || mul_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
      end else if (up_ready) begin
         mul_valid_ff <= up_valid;
      end
      if (up_valid && up_ready) begin
         nx_su_ff <= nx_su_in;
         ny_sv_ff <= ny_sv_in;
         s_dp_ff  <= s_dp_in;
         nx_sp_ff <= nx_sp_in;
         s_du_ff  <= s_du_in;
         ny_sp_ff <= ny_sp_in;
         s_dv_ff  <= s_dv_in;
      end
   end

   // Sum and negate each numerator at full width
   always_comb begin
      acc_p_in = '0 - ACC_W'(nx_su_ff) - ACC_W'(ny_sv_ff) - ACC_W'(s_dp_ff);
      acc_u_in = '0 - ACC_W'(nx_sp_ff) - ACC_W'(s_du_ff);
      acc_v_in = '0 - ACC_W'(ny_sp_ff) - ACC_W'(s_dv_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_valid_ff <= 1'b0;
      end else if (mul_ready) begin
         acc_valid_ff <= mul_valid_ff;
      end
      if (mul_valid_ff && mul_ready) begin
         acc_p_ff <= acc_p_in;
         acc_u_ff <= acc_u_in;
         acc_v_ff <= acc_v_in;
      end
   end

   // Floor, saturate and hold the item until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (acc_ready) begin
         out_valid_ff <= acc_valid_ff;
      end
      if (acc_valid_ff && acc_ready) begin
         flux_p_ff <= sat_word(acc_p_ff);
         flux_u_ff <= sat_word(acc_u_ff);
         flux_v_ff <= sat_word(acc_v_ff);
      end
   end

   assign rsp_valid  = out_valid_ff;
   assign rsp_flux_p = flux_p_ff;
   assign rsp_flux_u = flux_u_ff;
   assign rsp_flux_v = flux_v_ff;

   // A floored and saturated flux keeps the sign of its numerator
   a_sign_p: assert property (@(posedge clock) disable iff (reset)
      acc_valid_ff && acc_ready |=> flux_p_ff[WORD_W-1] == $past(acc_p_ff[ACC_W-1]))
      else $error("pressure flux sign mismatch");
   a_sign_u: assert property (@(posedge clock) disable iff (reset)
      acc_valid_ff && acc_ready |=> flux_u_ff[WORD_W-1] == $past(acc_u_ff[ACC_W-1]))
      else $error("x velocity flux sign mismatch");
   a_sign_v: assert property (@(posedge clock) disable iff (reset)
      acc_valid_ff && acc_ready |=> flux_v_ff[WORD_W-1] == $past(acc_v_ff[ACC_W-1]))
      else $error("y velocity flux sign mismatch");

endmodule

[design/rusanov_flux_acoustic_2d_top.sv]
// Top level of the 2D acoustic Rusanov face flux pipeline.
// Takes one face item per cycle while the output side does not stall and returns one
// flux item per face, in order, through two input stages (operand sums and squared
// normal, then the radicand), a chain of 32 square root cells that
// settle one bit of s = floor(sqrt(nx^2+ny^2)) each, and three output stages (products,
// numerators, floor with saturation). Every stage holds its own item, so a stalled
// output fills the pipeline bubble by bubble before req_ready drops.
module rusanov_flux_acoustic_2d_top
   import rfa_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic signed [WORD_W-1:0] req_left_p,
   input  logic signed [WORD_W-1:0] req_left_u,
   input  logic signed [WORD_W-1:0] req_left_v,
   input  logic signed [WORD_W-1:0] req_right_p,
   input  logic signed [WORD_W-1:0] req_right_u,
   input  logic signed [WORD_W-1:0] req_right_v,
   input  logic signed [WORD_W-1:0] req_normal_x,
   input  logic signed [WORD_W-1:0] req_normal_y,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [WORD_W-1:0] rsp_flux_p,
   output logic signed [WORD_W-1:0] rsp_flux_u,
   output logic signed [WORD_W-1:0] rsp_flux_v
);

   logic     link_valid [ROOT_CELLS+1];
   logic     link_ready [ROOT_CELLS+1];
   root_type link_node  [ROOT_CELLS+1];

   // Front stages
   rfa_norm u_norm (
      .clock    (clock),
      .reset    (reset),
      .up_valid (req_valid),
      .up_ready (req_ready),
      .left_p   (req_left_p),
      .left_u   (req_left_u),
      .left_v   (req_left_v),
      .right_p  (req_right_p),
      .right_u  (req_right_u),
      .right_v  (req_right_v),
      .normal_x (req_normal_x),
      .normal_y (req_normal_y),
      .dn_valid (link_valid[0]),
      .dn_ready (link_ready[0]),
      .dn_node  (link_node[0])
   );

   // Square root chain, most significant root bit first
   for (genvar i = 0; i < ROOT_CELLS; i++) begin : g_root
      rfa_root_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .up_valid (link_valid[i]),
         .up_ready (link_ready[i]),
         .up_node  (link_node[i]),
         .dn_valid (link_valid[i+1]),
         .dn_ready (link_ready[i+1]),
         .dn_node  (link_node[i+1])
      );
   end

   // Flux products and output register
   rfa_flux_tail u_tail (
      .clock      (clock),
      .reset      (reset),
      .up_valid   (link_valid[ROOT_CELLS]),
      .up_ready   (link_ready[ROOT_CELLS]),
      .up_face    (link_node[ROOT_CELLS].face),
      .up_root    (link_node[ROOT_CELLS].root),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_flux_p (rsp_flux_p),
      .rsp_flux_u (rsp_flux_u),
      .rsp_flux_v (rsp_flux_v)
   );

endmodule

[tb/sv/rfa_flux_checker.sv]
// Flux checker: watches both channels, predicts each face flux and compares the results.
module rfa_flux_checker
   import rfa_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_ready,
   input  logic signed [WORD_W-1:0] req_left_p,
   input  logic signed [WORD_W-1:0] req_left_u,
   input  logic signed [WORD_W-1:0] req_left_v,
   input  logic signed [WORD_W-1:0] req_right_p,
   input  logic signed [WORD_W-1:0] req_right_u,
   input  logic signed [WORD_W-1:0] req_right_v,
   input  logic signed [WORD_W-1:0] req_normal_x,
   input  logic signed [WORD_W-1:0] req_normal_y,
   input  logic                     rsp_valid,
   input  logic                     rsp_ready,
   input  logic signed [WORD_W-1:0] rsp_flux_p,
   input  logic signed [WORD_W-1:0] rsp_flux_u,
   input  logic signed [WORD_W-1:0] rsp_flux_v,
   output int                       mismatches,
   output int                       outstanding
);

   // Wide enough for every numerator without wrapping
   localparam int NUM_W = 80;
   typedef logic signed [NUM_W-1:0] num_t;

   typedef struct packed {
      logic signed [WORD_W-1:0] flux_p;
      logic signed [WORD_W-1:0] flux_u;
      logic signed [WORD_W-1:0] flux_v;
   } flux_t;

   flux_t flux_q[$];

   // Floor of the square root of a 64-bit radicand, one result bit per pass
   function automatic logic [WORD_W:0] floor_root(input logic [63:0] rad);
      logic [63:0] rest;
      logic [63:0] root;
      logic [63:0] probe;
      rest  = rad;
      root  = '0;
      probe = 64'd1 << 62;
      while (probe != 0) begin
         if (rest >= root + probe) begin
            rest = rest - (root + probe);
            root = (root >> 1) + probe;
         end else begin
            root = root >> 1;
         end
         probe = probe >> 2;
      end
      return root[WORD_W:0];
   endfunction

   // Floor divide by 2^(FRAC_BITS+1), then clamp to a signed word
   function automatic logic [WORD_W-1:0] floor_clamp(input num_t n);
      num_t q;
      q = n >>> (FRAC_BITS + 1);
      if (q[NUM_W-1:WORD_W-1] == '0 || q[NUM_W-1:WORD_W-1] == '1) begin
         return q[WORD_W-1:0];
      end else if (q[NUM_W-1]) begin
         return SAT_MIN;
      end else begin
         return SAT_MAX;
      end
   endfunction

   // Rusanov flux of the acoustic system for the face on the input ports
   function automatic flux_t rusanov_flux();
      logic [63:0] ax;
      logic [63:0] ay;
      num_t        nx;
      num_t        ny;
      num_t        s;
      num_t        sum_p;
      num_t        sum_u;
      num_t        sum_v;
      num_t        dif_p;
      num_t        dif_u;
      num_t        dif_v;
      flux_t       f;
      nx    = num_t'(req_normal_x);
      ny    = num_t'(req_normal_y);
      ax    = (nx < 0) ? 64'(-nx) : 64'(nx);
      ay    = (ny < 0) ? 64'(-ny) : 64'(ny);
      s     = {{(NUM_W-WORD_W-1){1'b0}}, floor_root(ax * ax + ay * ay)};
      sum_p = num_t'(req_left_p) + num_t'(req_right_p);
      sum_u = num_t'(req_left_u) + num_t'(req_right_u);
      sum_v = num_t'(req_left_v) + num_t'(req_right_v);
      dif_p = num_t'(req_right_p) - num_t'(req_left_p);
      dif_u = num_t'(req_right_u) - num_t'(req_left_u);
      dif_v = num_t'(req_right_v) - num_t'(req_left_v);
      f.flux_p = floor_clamp(-(nx * sum_u + ny * sum_v + s * dif_p));
      f.flux_u = floor_clamp(-(nx * sum_p + s * dif_u));
      f.flux_v = floor_clamp(-(ny * sum_p + s * dif_v));
      return f;
   endfunction

   task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
                                  input logic [WORD_W-1:0] want);
      $display("flux check failed at %0t: %s got %h want %h", $realtime, what, got, want);
      mismatches++;
   endtask

   // Compare each returned item with the oldest prediction, then queue the new face
   always @(posedge clock) begin
      flux_t want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (flux_q.size() == 0) begin
               report_mismatch("unexpected item flux_p", rsp_flux_p, '0);
            end else begin
               want = flux_q.pop_front();
               if (rsp_flux_p !== want.flux_p) report_mismatch("flux_p", rsp_flux_p, want.flux_p);
               if (rsp_flux_u !== want.flux_u) report_mismatch("flux_u", rsp_flux_u, want.flux_u);
               if (rsp_flux_v !== want.flux_v) report_mismatch("flux_v", rsp_flux_v, want.flux_v);
            end
         end
         if (req_valid && req_ready) begin
            flux_q.push_back(rusanov_flux());
         end
      end
      outstanding = flux_q.size();
   end

endmodule

[tb/sv/tb_rusanov_flux_acoustic_2d_top.sv]
// Testbench top: clock, reset, face stimulus, output stalls and the final verdict.
module tb_rusanov_flux_acoustic_2d_top;
   import rfa_pkg::*;

   localparam int HALF_PERIOD  = 4;
   localparam int HOLD_CYCLES  = 150;
   localparam int PHASE_ITEMS  = 100;
   localparam int DRAIN_CYCLES = 60;
   localparam logic [WORD_W-1:0] ONE = 32'h0001_0000;

   typedef struct packed {
      logic [WORD_W-1:0] lp;
      logic [WORD_W-1:0] lu;
      logic [WORD_W-1:0] lv;
      logic [WORD_W-1:0] rp;
      logic [WORD_W-1:0] ru;
      logic [WORD_W-1:0] rv;
      logic [WORD_W-1:0] nx;
      logic [WORD_W-1:0] ny;
   } face_item_t;

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_ready;
   logic signed [WORD_W-1:0] req_left_p;
   logic signed [WORD_W-1:0] req_left_u;
   logic signed [WORD_W-1:0] req_left_v;
   logic signed [WORD_W-1:0] req_right_p;
   logic signed [WORD_W-1:0] req_right_u;
   logic signed [WORD_W-1:0] req_right_v;
   logic signed [WORD_W-1:0] req_normal_x;
   logic signed [WORD_W-1:0] req_normal_y;
   logic                     rsp_valid;
   logic                     rsp_ready;
   logic signed [WORD_W-1:0] rsp_flux_p;
   logic signed [WORD_W-1:0] rsp_flux_u;
   logic signed [WORD_W-1:0] rsp_flux_v;
   int                       mismatches;
   int                       outstanding;

   int idle_pct;
   int stall_pct;
   int hold_ask;

   rusanov_flux_acoustic_2d_top i_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_left_p   (req_left_p),
      .req_left_u   (req_left_u),
      .req_left_v   (req_left_v),
      .req_right_p  (req_right_p),
      .req_right_u  (req_right_u),
      .req_right_v  (req_right_v),
      .req_normal_x (req_normal_x),
      .req_normal_y (req_normal_y),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_flux_p   (rsp_flux_p),
      .rsp_flux_u   (rsp_flux_u),
      .rsp_flux_v   (rsp_flux_v)
   );

   rfa_flux_checker i_checker (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_left_p   (req_left_p),
      .req_left_u   (req_left_u),
      .req_left_v   (req_left_v),
      .req_right_p  (req_right_p),
      .req_right_u  (req_right_u),
      .req_right_v  (req_right_v),
      .req_normal_x (req_normal_x),
      .req_normal_y (req_normal_y),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_flux_p   (rsp_flux_p),
      .rsp_flux_u   (rsp_flux_u),
      .rsp_flux_v   (rsp_flux_v),
      .mismatches   (mismatches),
      .outstanding  (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever begin
         #HALF_PERIOD clock = ~clock;
      end
   end

   // Stop a hung run
   initial begin
      #(2 * HALF_PERIOD * 200000);
      $display("rusanov_flux_acoustic_2d_top: mismatch");
      $finish;
   end

   // Drive the result ready: random stalls, plus a long hold whenever one is asked
   initial begin
      int hold_seen;
      int hold_left;
      hold_seen = 0;
      hold_left = 0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_ask != hold_seen) begin
            hold_seen = hold_ask;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   function automatic face_item_t make_face(
      input logic [WORD_W-1:0] lp, lu, lv, rp, ru, rv, nx, ny);
      face_item_t f;
      f = '{lp, lu, lv, rp, ru, rv, nx, ny};
      return f;
   endfunction

   // Pick a word: extremes, zero, full random, or a value near the working range
   function automatic logic [WORD_W-1:0] rand_word(input int span);
      case ($urandom_range(9))
         0: return SAT_MAX;
         1: return SAT_MIN;
         2: return '0;
         3, 4: return $urandom;
         default: return WORD_W'($urandom_range(0, 2 * span)) - WORD_W'(span);
      endcase
   endfunction

   function automatic face_item_t rand_face();
      face_item_t f;
      f.lp = rand_word(1 << 24);
      f.lu = rand_word(1 << 24);
      f.lv = rand_word(1 << 24);
      f.rp = rand_word(1 << 24);
      f.ru = rand_word(1 << 24);
      f.rv = rand_word(1 << 24);
      f.nx = rand_word(1 << 18);
      f.ny = rand_word(1 << 18);
      return f;
   endfunction

   // Offer one face after a random gap; return at the falling edge after it is taken
   task automatic send_face(input face_item_t f);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_left_p   <= f.lp;
      req_left_u   <= f.lu;
      req_left_v   <= f.lv;
      req_right_p  <= f.rp;
      req_right_u  <= f.ru;
      req_right_v  <= f.rv;
      req_normal_x <= f.nx;
      req_normal_y <= f.ny;
      req_valid    <= 1'b1;
      do begin
         @(posedge clock);
      end while (!req_ready);
      @(negedge clock);
   endtask

   initial begin
      face_item_t directed[$];
      int         idle_mix[4];
      int         stall_mix[4];
      idle_mix  = '{0, 58, 0, 33};
      stall_mix = '{0, 0, 58, 33};
      idle_pct     = 0;
      stall_pct    = 0;
      hold_ask     = 0;
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_left_p   = '0;
      req_left_u   = '0;
      req_left_v   = '0;
      req_right_p  = '0;
      req_right_u  = '0;
      req_right_v  = '0;
      req_normal_x = '0;
      req_normal_y = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed faces: zero, unit and extreme normals, saturation both ways, floors
      directed.push_back(make_face('0, '0, '0, '0, '0, '0, '0, '0));
      directed.push_back(make_face(ONE, ONE, ONE, ONE, ONE, ONE, ONE, '0));
      directed.push_back(make_face(ONE, -ONE, ONE, -ONE, ONE, -ONE, '0, ONE));
      directed.push_back(make_face(32'h0012_3456, 32'hFFF0_0001, 32'h0000_0003,
                                   32'h7654_3210, 32'h0000_0001, 32'hFFFF_FFFF, '0, '0));
      directed.push_back(make_face(SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX,
                                   SAT_MAX, SAT_MAX));
      directed.push_back(make_face(SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN,
                                   SAT_MIN, SAT_MIN));
      directed.push_back(make_face(SAT_MIN, SAT_MAX, SAT_MIN, SAT_MAX, SAT_MIN, SAT_MAX,
                                   SAT_MIN, SAT_MAX));
      directed.push_back(make_face(SAT_MAX, SAT_MIN, SAT_MAX, SAT_MIN, SAT_MAX, SAT_MIN,
                                   SAT_MAX, SAT_MIN));
      directed.push_back(make_face(ONE, 2 * ONE, 3 * ONE, -ONE, -2 * ONE, -3 * ONE,
                                   SAT_MIN, '0));
      directed.push_back(make_face(ONE, ONE, ONE, ONE, ONE, ONE, '0, SAT_MAX));
      directed.push_back(make_face(32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF,
                                   32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0001,
                                   32'h0000_0001, 32'hFFFF_FFFF));
      directed.push_back(make_face(32'h0000_0001, '0, '0, '0, '0, '0, 32'h0000_0003,
                                   32'h0000_0004));
      directed.push_back(make_face(32'hFFFF_8000, 32'h0000_7FFF, 32'h4000_0000,
                                   32'hC000_0000, 32'h0000_0001, 32'h8000_0001,
                                   32'h0000_B505, 32'hFFFF_4AFB));
      directed.push_back(make_face(SAT_MAX, '0, '0, SAT_MIN, '0, '0, ONE, ONE));
      directed.push_back(make_face('0, SAT_MAX, SAT_MIN, '0, SAT_MIN, SAT_MAX, ONE, -ONE));
      directed.push_back(make_face(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
                                   32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
                                   32'hAAAA_AAAA, 32'h5555_5555));
      foreach (directed[i]) begin
         send_face(directed[i]);
      end

      // Random faces over the idle and stall mixes; hold the output at the first one
      for (int ph = 0; ph < 4; ph++) begin
         idle_pct  = idle_mix[ph];
         stall_pct = stall_mix[ph];
         if (ph == 0) begin
            hold_ask++;
         end
         repeat (PHASE_ITEMS) begin
            send_face(rand_face());
         end
      end
      req_valid <= 1'b0;

      // Drain the pipeline and let it settle
      while (outstanding != 0) begin
         @(negedge clock);
      end
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatches == 0) begin
         $display("rusanov_flux_acoustic_2d_top: match");
      end else begin
         $display("rusanov_flux_acoustic_2d_top: mismatch");
      end
      $finish;
   end

endmodule
